### hdl/ccu_pkg.sv
package ccu_pkg;

  // input and output formats
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int LIMIT_W    = 34;
  localparam int OUT_W      = 40;

  // front arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int DET_W  = 2 * COORD_BITS + 3;
  localparam int ADET_W = DET_W - 1;
  localparam int NUM_W  = 3 * COORD_BITS + 3;
  localparam int MAG_W  = NUM_W - 1;

  // divider widths
  localparam int M_W     = MAG_W + FRAC_BITS + 1;
  localparam int D_W     = ADET_W + 1;
  localparam int Q_W     = OUT_W + 2;
  localparam int DIV_LAT = Q_W + 1;

  // radius path widths
  localparam int CX_W   = Q_W + 1;
  localparam int DX_W   = CX_W + 1;
  localparam int ADX_W  = DX_W - 1;
  localparam int LO_W   = (ADX_W + 1) / 2;
  localparam int HI_W   = ADX_W - LO_W;
  localparam int S_W    = 2 * ADX_W + 2;
  localparam int RT_W   = S_W / 2;
  localparam int R_W    = RT_W + 3;
  localparam int SQ_LAT = RT_W + 1;

  // queue between front and back
  localparam int FRONT_STAGES = 4;
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
  } pts_t;

  typedef struct packed {
    logic                         col;
    logic                         sx;
    logic                         sy;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
  } sb_t;

  typedef struct packed {
    logic [M_W-1:0] mx;
    logic [M_W-1:0] my;
    logic [D_W-1:0] d;
    sb_t            sb;
  } item_t;

  typedef struct packed {
    logic empty;
    logic afull;
  } fifo_stat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic                    collinear;
  } result_t;

endpackage

### hdl/ccu_front.sv
module ccu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  ccu_pkg::pts_t                 pts,
  input  logic [ccu_pkg::LIMIT_W-1:0]   limit,
  output logic                          push,
  output ccu_pkg::item_t                push_data
);

  // stage 1: differences and squared-norm differences
  logic                                v1_r;
  logic signed [ccu_pkg::DIFF_W-1:0]   a_r, b_r, c_r, d_r;
  logic signed [ccu_pkg::SQ_W-1:0]     e2_r, f2_r;
  logic signed [ccu_pkg::COORD_BITS-1:0] x1_1r, y1_1r;

  logic signed [2*ccu_pkg::COORD_BITS-1:0] sqx1, sqy1, sqx2, sqy2, sqx3, sqy3;
  logic signed [ccu_pkg::DIFF_W-1:0]   a_nxt, b_nxt, c_nxt, d_nxt;
  logic signed [ccu_pkg::SQ_W-1:0]     e2_nxt, f2_nxt;

  always_comb begin
    a_nxt  = ccu_pkg::DIFF_W'(pts.p1_x) - ccu_pkg::DIFF_W'(pts.p2_x);
    b_nxt  = ccu_pkg::DIFF_W'(pts.p1_y) - ccu_pkg::DIFF_W'(pts.p2_y);
    c_nxt  = ccu_pkg::DIFF_W'(pts.p1_x) - ccu_pkg::DIFF_W'(pts.p3_x);
    d_nxt  = ccu_pkg::DIFF_W'(pts.p1_y) - ccu_pkg::DIFF_W'(pts.p3_y);
    sqx1   = pts.p1_x * pts.p1_x;
    sqy1   = pts.p1_y * pts.p1_y;
    sqx2   = pts.p2_x * pts.p2_x;
    sqy2   = pts.p2_y * pts.p2_y;
    sqx3   = pts.p3_x * pts.p3_x;
    sqy3   = pts.p3_y * pts.p3_y;
    e2_nxt = ccu_pkg::SQ_W'(sqx1) - ccu_pkg::SQ_W'(sqx2)
           + ccu_pkg::SQ_W'(sqy1) - ccu_pkg::SQ_W'(sqy2);
    f2_nxt = ccu_pkg::SQ_W'(sqx1) - ccu_pkg::SQ_W'(sqx3)
           + ccu_pkg::SQ_W'(sqy1) - ccu_pkg::SQ_W'(sqy3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_take;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e2_r  <= e2_nxt;
    f2_r  <= f2_nxt;
    x1_1r <= pts.p1_x;
    y1_1r <= pts.p1_y;
  end

  // stage 2: determinant and center numerators
  logic                                v2_r;
  logic signed [ccu_pkg::DET_W-1:0]    det_r;
  logic signed [ccu_pkg::NUM_W-1:0]    nx_r, ny_r;
  logic signed [ccu_pkg::COORD_BITS-1:0] x1_2r, y1_2r;

  logic signed [ccu_pkg::DET_W-1:0]    det_nxt;
  logic signed [ccu_pkg::NUM_W-1:0]    nx_nxt, ny_nxt;

  always_comb begin
    det_nxt = ccu_pkg::DET_W'(b_r) * ccu_pkg::DET_W'(c_r)
            - ccu_pkg::DET_W'(a_r) * ccu_pkg::DET_W'(d_r);
    nx_nxt  = ccu_pkg::NUM_W'(b_r) * ccu_pkg::NUM_W'(f2_r)
            - ccu_pkg::NUM_W'(d_r) * ccu_pkg::NUM_W'(e2_r);
    ny_nxt  = ccu_pkg::NUM_W'(c_r) * ccu_pkg::NUM_W'(e2_r)
            - ccu_pkg::NUM_W'(a_r) * ccu_pkg::NUM_W'(f2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    det_r <= det_nxt;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    x1_2r <= x1_1r;
    y1_2r <= y1_1r;
  end

  // stage 3: magnitudes and result signs
  logic                                v3_r;
  logic [ccu_pkg::ADET_W-1:0]          adet_r;
  logic [ccu_pkg::MAG_W-1:0]           anx_r, any_r;
  logic                                sx_3r, sy_3r;
  logic signed [ccu_pkg::COORD_BITS-1:0] x1_3r, y1_3r;

  logic [ccu_pkg::ADET_W-1:0]          adet_nxt;
  logic [ccu_pkg::MAG_W-1:0]           anx_nxt, any_nxt;

  always_comb begin
    adet_nxt = det_r[ccu_pkg::DET_W-1] ? ccu_pkg::ADET_W'(-det_r) : ccu_pkg::ADET_W'(det_r);
    anx_nxt  = nx_r[ccu_pkg::NUM_W-1] ? ccu_pkg::MAG_W'(-nx_r) : ccu_pkg::MAG_W'(nx_r);
    any_nxt  = ny_r[ccu_pkg::NUM_W-1] ? ccu_pkg::MAG_W'(-ny_r) : ccu_pkg::MAG_W'(ny_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    adet_r <= adet_nxt;
    anx_r  <= anx_nxt;
    any_r  <= any_nxt;
    sx_3r  <= nx_r[ccu_pkg::NUM_W-1] ^ det_r[ccu_pkg::DET_W-1];
    sy_3r  <= ny_r[ccu_pkg::NUM_W-1] ^ det_r[ccu_pkg::DET_W-1];
    x1_3r  <= x1_2r;
    y1_3r  <= y1_2r;
  end

  // stage 4: collinear test and rounded dividends
  logic           v4_r;
  ccu_pkg::item_t item_r;
  ccu_pkg::item_t item_nxt;

  always_comb begin
    item_nxt.mx    = (ccu_pkg::M_W'(anx_r) << ccu_pkg::FRAC_BITS) + ccu_pkg::M_W'(adet_r);
    item_nxt.my    = (ccu_pkg::M_W'(any_r) << ccu_pkg::FRAC_BITS) + ccu_pkg::M_W'(adet_r);
    item_nxt.d     = {adet_r, 1'b0};
    item_nxt.sb.col = ccu_pkg::LIMIT_W'(adet_r) <= limit;
    item_nxt.sb.sx = sx_3r;
    item_nxt.sb.sy = sy_3r;
    item_nxt.sb.x1 = x1_3r;
    item_nxt.sb.y1 = y1_3r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    item_r <= item_nxt;
  end

  assign push      = v4_r;
  assign push_data = item_r;

endmodule

### hdl/ccu_fifo.sv
module ccu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ccu_pkg::item_t      push_data,
  input  logic                pop,
  output ccu_pkg::item_t      pop_data,
  output ccu_pkg::fifo_stat_t stat
);

  ccu_pkg::item_t              ent_r [0:ccu_pkg::FIFO_DEPTH-1];
  logic [ccu_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ccu_pkg::FIFO_AW:0]   cnt_r;
  logic                        do_pop;

  assign do_pop = pop && (cnt_r != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (ccu_pkg::FIFO_AW+1)'(push) - (ccu_pkg::FIFO_AW+1)'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = ent_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.afull = cnt_r >= (ccu_pkg::FIFO_AW+1)'(ccu_pkg::FIFO_DEPTH - ccu_pkg::FRONT_STAGES);

endmodule

### hdl/ccu_div.sv
module ccu_div (
  input  logic                      clk,
  input  logic [ccu_pkg::M_W-1:0]   m,
  input  logic [ccu_pkg::D_W-1:0]   d,
  output logic [ccu_pkg::Q_W-1:0]   q,
  output logic                      ovf
);

  logic [ccu_pkg::D_W-1:0] rem_r [0:ccu_pkg::Q_W];
  logic [ccu_pkg::Q_W-1:0] ml_r  [0:ccu_pkg::Q_W];
  logic [ccu_pkg::D_W-1:0] d_r   [0:ccu_pkg::Q_W];
  logic [ccu_pkg::Q_W-1:0] q_r   [0:ccu_pkg::Q_W];
  logic                    ovf_r [0:ccu_pkg::Q_W];

  // entry stage: quotient range check and top of dividend
  always_ff @(posedge clk) begin
    ovf_r[0] <= (ccu_pkg::D_W+ccu_pkg::Q_W)'(m) >= {d, {ccu_pkg::Q_W{1'b0}}};
    rem_r[0] <= ccu_pkg::D_W'(m[ccu_pkg::M_W-1:ccu_pkg::Q_W]);
    ml_r[0]  <= m[ccu_pkg::Q_W-1:0];
    d_r[0]   <= d;
    q_r[0]   <= '0;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= ccu_pkg::Q_W; k++) begin : g_stage
    logic [ccu_pkg::D_W:0] t_nxt, diff_nxt;
    logic                  ge_nxt;

    always_comb begin
      t_nxt    = {rem_r[k-1], ml_r[k-1][ccu_pkg::Q_W-k]};
      diff_nxt = t_nxt - {1'b0, d_r[k-1]};
      ge_nxt   = t_nxt >= {1'b0, d_r[k-1]};
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge_nxt ? diff_nxt[ccu_pkg::D_W-1:0] : t_nxt[ccu_pkg::D_W-1:0];
      q_r[k]   <= {q_r[k-1][ccu_pkg::Q_W-2:0], ge_nxt};
      ml_r[k]  <= ml_r[k-1];
      d_r[k]   <= d_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign q   = q_r[ccu_pkg::Q_W];
  assign ovf = ovf_r[ccu_pkg::Q_W];

endmodule

### hdl/ccu_sqrt.sv
module ccu_sqrt (
  input  logic                      clk,
  input  logic [ccu_pkg::S_W-1:0]   s,
  output logic [ccu_pkg::RT_W-1:0]  root,
  output logic [ccu_pkg::R_W-1:0]   rem
);

  logic [ccu_pkg::S_W-1:0]  s_r [0:ccu_pkg::RT_W];
  logic [ccu_pkg::R_W-1:0]  r_r [0:ccu_pkg::RT_W];
  logic [ccu_pkg::RT_W-1:0] q_r [0:ccu_pkg::RT_W];

  // entry stage
  always_ff @(posedge clk) begin
    s_r[0] <= s;
    r_r[0] <= '0;
    q_r[0] <= '0;
  end

  // one root bit per stage, two radicand bits consumed
  for (genvar k = 1; k <= ccu_pkg::RT_W; k++) begin : g_stage
    logic [ccu_pkg::R_W-1:0] rs_nxt, t_nxt;
    logic                    ge_nxt;

    always_comb begin
      rs_nxt = {r_r[k-1][ccu_pkg::R_W-3:0], s_r[k-1][ccu_pkg::S_W-1 -: 2]};
      t_nxt  = ccu_pkg::R_W'({q_r[k-1], 2'b01});
      ge_nxt = rs_nxt >= t_nxt;
    end

    always_ff @(posedge clk) begin
      r_r[k] <= ge_nxt ? rs_nxt - t_nxt : rs_nxt;
      q_r[k] <= {q_r[k-1][ccu_pkg::RT_W-2:0], ge_nxt};
      s_r[k] <= s_r[k-1] << 2;
    end
  end

  assign root = q_r[ccu_pkg::RT_W];
  assign rem  = r_r[ccu_pkg::RT_W];

endmodule

### hdl/ccu_back.sv
module ccu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  ccu_pkg::item_t   item,
  output logic             res_strobe,
  output ccu_pkg::result_t res
);

  // dividers for both center coordinates
  logic [ccu_pkg::Q_W-1:0] qx, qy;
  logic                    ovfx, ovfy;

  ccu_div u_div_x (.clk(clk), .m(item.mx), .d(item.d), .q(qx), .ovf(ovfx));
  ccu_div u_div_y (.clk(clk), .m(item.my), .d(item.d), .q(qy), .ovf(ovfy));

  // side information travels alongside the dividers
  logic        dv_r  [0:ccu_pkg::DIV_LAT-1];
  ccu_pkg::sb_t dsb_r [0:ccu_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ccu_pkg::DIV_LAT; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else begin
      dv_r[0] <= in_take;
      for (int i = 1; i < ccu_pkg::DIV_LAT; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
    dsb_r[0] <= item.sb;
    for (int i = 1; i < ccu_pkg::DIV_LAT; i++) begin
      dsb_r[i] <= dsb_r[i-1];
    end
  end

  ccu_pkg::sb_t sb_d;
  assign sb_d = dsb_r[ccu_pkg::DIV_LAT-1];

  // b1: saturated centers, signed centers for the radius
  logic                               v1_r, col1_r, big1_r;
  logic signed [ccu_pkg::OUT_W-1:0]   cxo1_r, cyo1_r;
  logic signed [ccu_pkg::CX_W-1:0]    cx1_r, cy1_r;
  logic signed [ccu_pkg::COORD_BITS-1:0] x1_1r, y1_1r;

  logic signed [ccu_pkg::OUT_W-1:0]   cxo_nxt, cyo_nxt;
  logic signed [ccu_pkg::CX_W-1:0]    cx_nxt, cy_nxt;
  logic                               satx, saty;
  logic [ccu_pkg::OUT_W-1:0]          pos_max, neg_min;

  always_comb begin
    pos_max = {1'b0, {(ccu_pkg::OUT_W-1){1'b1}}};
    neg_min = {1'b1, {(ccu_pkg::OUT_W-1){1'b0}}};
    satx = ovfx || (qx[ccu_pkg::Q_W-1:ccu_pkg::OUT_W-1] != '0);
    saty = ovfy || (qy[ccu_pkg::Q_W-1:ccu_pkg::OUT_W-1] != '0);
    if (satx) begin
      cxo_nxt = sb_d.sx ? neg_min : pos_max;
    end else begin
      cxo_nxt = sb_d.sx ? -qx[ccu_pkg::OUT_W-1:0] : qx[ccu_pkg::OUT_W-1:0];
    end
    if (saty) begin
      cyo_nxt = sb_d.sy ? neg_min : pos_max;
    end else begin
      cyo_nxt = sb_d.sy ? -qy[ccu_pkg::OUT_W-1:0] : qy[ccu_pkg::OUT_W-1:0];
    end
    cx_nxt = sb_d.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    cy_nxt = sb_d.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= dv_r[ccu_pkg::DIV_LAT-1];
    end
    col1_r <= sb_d.col;
    big1_r <= ovfx || ovfy || qx[ccu_pkg::Q_W-1] || qy[ccu_pkg::Q_W-1];
    cxo1_r <= cxo_nxt;
    cyo1_r <= cyo_nxt;
    cx1_r  <= cx_nxt;
    cy1_r  <= cy_nxt;
    x1_1r  <= sb_d.x1;
    y1_1r  <= sb_d.y1;
  end

  // b2: offsets from the first point
  logic                            v2_r, col2_r, big2_r;
  logic signed [ccu_pkg::OUT_W-1:0] cxo2_r, cyo2_r;
  logic signed [ccu_pkg::DX_W-1:0] dx2_r, dy2_r;
  logic signed [ccu_pkg::DX_W-1:0] x1s, y1s;

  always_comb begin
    x1s = ccu_pkg::DX_W'(x1_1r) <<< ccu_pkg::FRAC_BITS;
    y1s = ccu_pkg::DX_W'(y1_1r) <<< ccu_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    col2_r <= col1_r;
    big2_r <= big1_r;
    cxo2_r <= cxo1_r;
    cyo2_r <= cyo1_r;
    dx2_r  <= x1s - ccu_pkg::DX_W'(cx1_r);
    dy2_r  <= y1s - ccu_pkg::DX_W'(cy1_r);
  end

  // b3: magnitudes of the offsets
  logic                             v3_r, col3_r, big3_r;
  logic signed [ccu_pkg::OUT_W-1:0] cxo3_r, cyo3_r;
  logic [ccu_pkg::ADX_W-1:0]        adx3_r, ady3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    col3_r <= col2_r;
    big3_r <= big2_r;
    cxo3_r <= cxo2_r;
    cyo3_r <= cyo2_r;
    adx3_r <= dx2_r[ccu_pkg::DX_W-1] ? ccu_pkg::ADX_W'(-dx2_r) : ccu_pkg::ADX_W'(dx2_r);
    ady3_r <= dy2_r[ccu_pkg::DX_W-1] ? ccu_pkg::ADX_W'(-dy2_r) : ccu_pkg::ADX_W'(dy2_r);
  end

  // b4: partial products of the squares
  logic                                    v4_r, col4_r, big4_r;
  logic signed [ccu_pkg::OUT_W-1:0]        cxo4_r, cyo4_r;
  logic [2*ccu_pkg::HI_W-1:0]              hhx_r, hhy_r;
  logic [ccu_pkg::HI_W+ccu_pkg::LO_W-1:0]  hlx_r, hly_r;
  logic [2*ccu_pkg::LO_W-1:0]              llx_r, lly_r;

  logic [ccu_pkg::HI_W-1:0] hx, hy;
  logic [ccu_pkg::LO_W-1:0] lx, ly;

  assign hx = adx3_r[ccu_pkg::ADX_W-1:ccu_pkg::LO_W];
  assign lx = adx3_r[ccu_pkg::LO_W-1:0];
  assign hy = ady3_r[ccu_pkg::ADX_W-1:ccu_pkg::LO_W];
  assign ly = ady3_r[ccu_pkg::LO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    col4_r <= col3_r;
    big4_r <= big3_r;
    cxo4_r <= cxo3_r;
    cyo4_r <= cyo3_r;
    hhx_r  <= (2*ccu_pkg::HI_W)'(hx) * (2*ccu_pkg::HI_W)'(hx);
    hhy_r  <= (2*ccu_pkg::HI_W)'(hy) * (2*ccu_pkg::HI_W)'(hy);
    hlx_r  <= (ccu_pkg::HI_W+ccu_pkg::LO_W)'(hx) * (ccu_pkg::HI_W+ccu_pkg::LO_W)'(lx);
    hly_r  <= (ccu_pkg::HI_W+ccu_pkg::LO_W)'(hy) * (ccu_pkg::HI_W+ccu_pkg::LO_W)'(ly);
    llx_r  <= (2*ccu_pkg::LO_W)'(lx) * (2*ccu_pkg::LO_W)'(lx);
    lly_r  <= (2*ccu_pkg::LO_W)'(ly) * (2*ccu_pkg::LO_W)'(ly);
  end

  // b5: full squares
  logic                             v5_r, col5_r, big5_r;
  logic signed [ccu_pkg::OUT_W-1:0] cxo5_r, cyo5_r;
  logic [ccu_pkg::S_W-1:0]          sqx5_r, sqy5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    col5_r <= col4_r;
    big5_r <= big4_r;
    cxo5_r <= cxo4_r;
    cyo5_r <= cyo4_r;
    sqx5_r <= (ccu_pkg::S_W'(hhx_r) << (2*ccu_pkg::LO_W))
            + (ccu_pkg::S_W'(hlx_r) << (ccu_pkg::LO_W+1)) + ccu_pkg::S_W'(llx_r);
    sqy5_r <= (ccu_pkg::S_W'(hhy_r) << (2*ccu_pkg::LO_W))
            + (ccu_pkg::S_W'(hly_r) << (ccu_pkg::LO_W+1)) + ccu_pkg::S_W'(lly_r);
  end

  // square root of the squared radius
  logic [ccu_pkg::RT_W-1:0] root;
  logic [ccu_pkg::R_W-1:0]  rem;

  ccu_sqrt u_sqrt (.clk(clk), .s(sqx5_r + sqy5_r), .root(root), .rem(rem));

  // side information alongside the root pipeline
  logic                             sv_r   [0:ccu_pkg::SQ_LAT-1];
  logic                             scol_r [0:ccu_pkg::SQ_LAT-1];
  logic                             sbig_r [0:ccu_pkg::SQ_LAT-1];
  logic signed [ccu_pkg::OUT_W-1:0] scx_r  [0:ccu_pkg::SQ_LAT-1];
  logic signed [ccu_pkg::OUT_W-1:0] scy_r  [0:ccu_pkg::SQ_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ccu_pkg::SQ_LAT; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else begin
      sv_r[0] <= v5_r;
      for (int i = 1; i < ccu_pkg::SQ_LAT; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
    scol_r[0] <= col5_r;
    sbig_r[0] <= big5_r;
    scx_r[0]  <= cxo5_r;
    scy_r[0]  <= cyo5_r;
    for (int i = 1; i < ccu_pkg::SQ_LAT; i++) begin
      scol_r[i] <= scol_r[i-1];
      sbig_r[i] <= sbig_r[i-1];
      scx_r[i]  <= scx_r[i-1];
      scy_r[i]  <= scy_r[i-1];
    end
  end

  // final rounding, saturation and collinear override
  logic             strobe_r;
  ccu_pkg::result_t res_r;
  ccu_pkg::result_t res_nxt;
  logic [ccu_pkg::RT_W:0] rr;
  logic                   col_f;

  always_comb begin
    col_f = scol_r[ccu_pkg::SQ_LAT-1];
    rr    = (ccu_pkg::RT_W+1)'(root) + (ccu_pkg::RT_W+1)'(rem > ccu_pkg::R_W'(root));
    res_nxt.collinear = col_f;
    if (col_f) begin
      res_nxt.center_x = '0;
      res_nxt.center_y = '0;
      res_nxt.radius   = '0;
    end else begin
      res_nxt.center_x = scx_r[ccu_pkg::SQ_LAT-1];
      res_nxt.center_y = scy_r[ccu_pkg::SQ_LAT-1];
      if (sbig_r[ccu_pkg::SQ_LAT-1] || (rr[ccu_pkg::RT_W:ccu_pkg::OUT_W] != '0)) begin
        res_nxt.radius = '1;
      end else begin
        res_nxt.radius = rr[ccu_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sv_r[ccu_pkg::SQ_LAT-1];
    end
    res_r <= res_nxt;
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

### hdl/circumcircle_from_three_points_unit.sv
// circumcircle of three integer points
//
// input channel: present the six coordinates with start high; the word is
// taken at a rising edge where start is high and busy is low. busy only
// rises if the queue between front and back reaches its almost-full mark,
// which does not happen in steady use, so a new word may be given every cycle.
// result channel: out_strobe is high for one cycle with center, radius and
// collinear flag; the receiver must take it then, it cannot stall the block.
// pipeline: an accepted word passes the 4 front stages, the queue, a
// 43-stage radix-2 divider per center coordinate, 5 radius stages, a
// 45-stage bit-per-stage square root and the output register.
// throughput: one word per cycle while busy is low, set by the fully
// pipelined divider and square root.
// configuration: cfg_we writes cfg_wdata into the collinear limit at once;
// write it only while no word is in flight.
// reset: rst_n low clears the limit to zero, empties the queue and drops
// all words in flight.
module circumcircle_from_three_points_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ccu_pkg::COORD_BITS-1:0] in_p1_x,
  input  logic signed [ccu_pkg::COORD_BITS-1:0] in_p1_y,
  input  logic signed [ccu_pkg::COORD_BITS-1:0] in_p2_x,
  input  logic signed [ccu_pkg::COORD_BITS-1:0] in_p2_y,
  input  logic signed [ccu_pkg::COORD_BITS-1:0] in_p3_x,
  input  logic signed [ccu_pkg::COORD_BITS-1:0] in_p3_y,
  input  logic                                 cfg_we,
  input  logic [ccu_pkg::LIMIT_W-1:0]          cfg_wdata,
  output logic                                 out_strobe,
  output logic signed [ccu_pkg::OUT_W-1:0]     out_center_x,
  output logic signed [ccu_pkg::OUT_W-1:0]     out_center_y,
  output logic [ccu_pkg::OUT_W-1:0]            out_radius,
  output logic                                 out_collinear
);

  // collinear limit register
  logic [ccu_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  ccu_pkg::pts_t       pts;
  ccu_pkg::item_t      push_data, pop_data;
  ccu_pkg::fifo_stat_t stat;
  ccu_pkg::result_t    res;
  logic                push, pop, take;

  assign pts.p1_x = in_p1_x;
  assign pts.p1_y = in_p1_y;
  assign pts.p2_x = in_p2_x;
  assign pts.p2_y = in_p2_y;
  assign pts.p3_x = in_p3_x;
  assign pts.p3_y = in_p3_y;

  assign busy = stat.afull;
  assign take = start && !stat.afull;
  assign pop  = !stat.empty;

  ccu_front u_front (
    .clk(clk), .rst_n(rst_n), .in_take(take), .pts(pts), .limit(limit_r),
    .push(push), .push_data(push_data)
  );

  ccu_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .stat(stat)
  );

  ccu_back u_back (
    .clk(clk), .rst_n(rst_n), .in_take(pop), .item(pop_data),
    .res_strobe(out_strobe), .res(res)
  );

  assign out_center_x  = res.center_x;
  assign out_center_y  = res.center_y;
  assign out_radius    = res.radius;
  assign out_collinear = res.collinear;

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 120;
  localparam int PHASE_WORDS = 200;
  localparam longint unsigned LIMIT_MAX = 64'h3_FFFF_FFFF;

  typedef struct {
    ccu_pkg::pts_t    pts;
    bit               known;
    ccu_pkg::result_t circ;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [ccu_pkg::COORD_BITS-1:0] in_p1_x, in_p1_y, in_p2_x, in_p2_y, in_p3_x, in_p3_y;
  logic cfg_we;
  logic [ccu_pkg::LIMIT_W-1:0] cfg_wdata;
  logic out_strobe;
  logic signed [ccu_pkg::OUT_W-1:0] out_center_x, out_center_y;
  logic [ccu_pkg::OUT_W-1:0] out_radius;
  logic out_collinear;

  ccu_pkg::result_t circle_q[$];
  longint unsigned col_limit;
  int idle_pct;
  int err_cnt;
  int cyc_cnt;

  circumcircle_from_three_points_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_p1_x(in_p1_x), .in_p1_y(in_p1_y), .in_p2_x(in_p2_x),
    .in_p2_y(in_p2_y), .in_p3_x(in_p3_x), .in_p3_y(in_p3_y),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_center_x(out_center_x),
    .out_center_y(out_center_y), .out_radius(out_radius),
    .out_collinear(out_collinear)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // rounded sqrt of a wide square
  function automatic longint unsigned round_sqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    if (s > r * r + r) r = r + 1;
    return r[63:0];
  endfunction

  // rounded center quotient magnitude for one axis, before saturation
  function automatic longint unsigned center_mag(longint num, longint unsigned adet);
    longint unsigned m;
    m = (num < 0) ? longint'(-num) : longint'(num);
    return ((m << ccu_pkg::FRAC_BITS) + adet) / (adet << 1);
  endfunction

  function automatic logic [ccu_pkg::OUT_W-1:0] sat_center(longint unsigned q, bit neg);
    longint unsigned pmax;
    longint v;
    pmax = (64'd1 << (ccu_pkg::OUT_W - 1)) - 1;
    if (q > pmax) begin
      return neg ? {1'b1, {(ccu_pkg::OUT_W-1){1'b0}}} : pmax[ccu_pkg::OUT_W-1:0];
    end
    v = neg ? -longint'(q) : longint'(q);
    return v[ccu_pkg::OUT_W-1:0];
  endfunction

  // circle through the three points under the current limit
  function automatic ccu_pkg::result_t circumcircle(ccu_pkg::pts_t p);
    ccu_pkg::result_t res;
    longint x1, y1, x2, y2, x3, y3, a, b, c, d, e2, f2, det, nx, ny, cx, cy, dx, dy;
    longint unsigned adet, qx, qy;
    bit sx, sy;
    logic signed [127:0] dxw, dyw;
    longint unsigned r;
    x1 = p.p1_x; y1 = p.p1_y; x2 = p.p2_x; y2 = p.p2_y; x3 = p.p3_x; y3 = p.p3_y;
    a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
    e2 = (x1 * x1 - x2 * x2) + (y1 * y1 - y2 * y2);
    f2 = (x1 * x1 - x3 * x3) + (y1 * y1 - y3 * y3);
    det = b * c - a * d;
    adet = (det < 0) ? longint'(-det) : longint'(det);
    res = '0;
    if (adet <= col_limit) begin
      res.collinear = 1'b1;
      return res;
    end
    nx = b * f2 - d * e2;
    ny = c * e2 - a * f2;
    qx = center_mag(nx, adet);
    qy = center_mag(ny, adet);
    sx = (nx < 0) != (det < 0);
    sy = (ny < 0) != (det < 0);
    res.center_x = sat_center(qx, sx);
    res.center_y = sat_center(qy, sy);
    if (qx >= (64'd1 << 41) || qy >= (64'd1 << 41)) begin
      res.radius = '1;
    end else begin
      cx = sx ? -longint'(qx) : longint'(qx);
      cy = sy ? -longint'(qy) : longint'(qy);
      dx = x1 * (64'sd1 <<< ccu_pkg::FRAC_BITS) - cx;
      dy = y1 * (64'sd1 <<< ccu_pkg::FRAC_BITS) - cy;
      dxw = dx;
      dyw = dy;
      r = round_sqrt(dxw * dxw + dyw * dyw);
      res.radius = (r > 64'hFF_FFFF_FFFF) ? '1 : r[ccu_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  function automatic stim_row_t row(int x1, int y1, int x2, int y2, int x3, int y3,
                                    bit known, longint cxv, longint cyv,
                                    longint rv, bit col);
    stim_row_t s;
    s.pts = '{x1[15:0], y1[15:0], x2[15:0], y2[15:0], x3[15:0], y3[15:0]};
    s.known = known;
    s.circ.center_x = cxv[ccu_pkg::OUT_W-1:0];
    s.circ.center_y = cyv[ccu_pkg::OUT_W-1:0];
    s.circ.radius = rv[ccu_pkg::OUT_W-1:0];
    s.circ.collinear = col;
    return s;
  endfunction

  function automatic int rnd_small();
    return int'($urandom_range(0, 128)) - 64;
  endfunction

  // random triangle: wide, small, nearly flat or with shared points
  function automatic ccu_pkg::pts_t rand_pts();
    ccu_pkg::pts_t p;
    int kind, k, dx, dy;
    kind = int'($urandom_range(0, 9));
    p = {$urandom, $urandom, $urandom};
    if (kind >= 4 && kind <= 6) begin
      p = '{16'(rnd_small()), 16'(rnd_small()), 16'(rnd_small()),
            16'(rnd_small()), 16'(rnd_small()), 16'(rnd_small())};
    end else if (kind >= 7 && kind <= 8) begin
      dx = rnd_small();
      dy = rnd_small();
      k = int'($urandom_range(0, 200)) - 100;
      p.p2_x = 16'(p.p1_x + dx);
      p.p2_y = 16'(p.p1_y + dy);
      p.p3_x = 16'(p.p1_x + k * dx + int'($urandom_range(0, 4)) - 2);
      p.p3_y = 16'(p.p1_y + k * dy + int'($urandom_range(0, 4)) - 2);
    end else if (kind == 9) begin
      if ($urandom_range(0, 1)) begin
        p.p2_x = p.p1_x;
        p.p2_y = p.p1_y;
      end else begin
        p.p3_x = p.p2_x;
        p.p3_y = p.p2_y;
      end
    end
    return p;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    ccu_pkg::result_t want;
    if (rst_n && out_strobe) begin
      if (circle_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result word at cycle %0d", cyc_cnt);
      end else begin
        want = circle_q.pop_front();
        if (out_center_x !== want.center_x || out_center_y !== want.center_y ||
            out_radius !== want.radius || out_collinear !== want.collinear) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp cx=%0d cy=%0d r=%0d col=%0b got cx=%0d cy=%0d r=%0d col=%0b",
                     want.center_x, want.center_y, want.radius, want.collinear,
                     out_center_x, out_center_y, out_radius, out_collinear);
        end
      end
    end
  end

  // send one word, with random gaps before it
  task automatic send_word(ccu_pkg::pts_t p, bit known, ccu_pkg::result_t given);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    {in_p1_x, in_p1_y, in_p2_x, in_p2_y, in_p3_x, in_p3_y} <= p;
    do @(posedge clk); while (busy);
    circle_q.push_back(known ? given : circumcircle(p));
    @(negedge clk);
  endtask

  // drain the pipe, then write the limit
  task automatic set_limit(longint unsigned v);
    start <= 1'b0;
    @(negedge clk);
    while (circle_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[ccu_pkg::LIMIT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    col_limit = v;
  endtask

  initial begin
    stim_row_t dir_tab[$];
    ccu_pkg::result_t none;
    longint unsigned limits[4];
    int pct[4];
    none = '0;
    err_cnt = 0;
    cyc_cnt = 0;
    col_limit = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    {in_p1_x, in_p1_y, in_p2_x, in_p2_y, in_p3_x, in_p3_y} = '0;

    // all points equal, shared points and straight lines give a flagged zero circle
    dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    dir_tab.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0, 0, 1));
    dir_tab.push_back(row(32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 0, 1));
    dir_tab.push_back(row(5, 7, 5, 7, -300, 900, 1, 0, 0, 0, 1));
    dir_tab.push_back(row(0, 0, 1, 1, 2, 2, 1, 0, 0, 0, 1));
    dir_tab.push_back(row(-32768, 0, 0, 0, 32767, 0, 1, 0, 0, 0, 1));
    // right triangle with legs of two, center (1,1)
    dir_tab.push_back(row(0, 0, 2, 0, 0, 2, 1, 256, 256, 362, 0));
    // corners of the coordinate range
    dir_tab.push_back(row(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(-32768, 32767, 32767, 32767, 0, -32768, 0, 0, 0, 0, 0));
    // determinant of one: far center, saturated outputs; the last row has determinant 65536
    dir_tab.push_back(row(0, 0, 32767, 32766, 32766, 32765, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(0, 0, -32767, -32766, -32766, -32765, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(-32768, -32768, 32767, 32766, 32766, 32764, 0, 0, 0, 0, 0));
    // alternating bit patterns
    dir_tab.push_back(row(21845, -21846, -21846, 21845, 3, -4, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(1, -1, -1, 1, 1, 1, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].pts, dir_tab[i].known, dir_tab[i].circ);

    // random phases, each with its own limit; the second and fourth add idle gaps
    limits = '{0, LIMIT_MAX, 64'd0, 64'd0};
    limits[2] = $urandom_range(1, 5000);
    limits[3] = {$urandom_range(0, 3), $urandom} & LIMIT_MAX;
    pct = '{0, 67, 0, 35};
    for (int ph = 0; ph < 4; ph++) begin
      set_limit(limits[ph]);
      idle_pct = pct[ph];
      for (int n = 0; n < PHASE_WORDS; n++) send_word(rand_pts(), 1'b0, none);
    end
    set_limit(0);
    idle_pct = 0;
    for (int n = 0; n < 20; n++) send_word(rand_pts(), 1'b0, none);

    // wait for the last words to come out
    start <= 1'b0;
    while (circle_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
